### design/assert_macros.svh
// Shared assertion helpers; clk_i and rst_ni must be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is active.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/tksd_pkg.sv
package tksd_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned RowW   = 48;
  localparam int unsigned RankW  = 6;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgW   = 16;

  localparam int unsigned MaxKept   = 64;
  localparam int unsigned SeenDepth = 1024;

  localparam logic [6:0]  DefCapacity = 7'd64;
  localparam logic [6:0]  DefLimit    = 7'd10;
  localparam logic [15:0] DefDrop     = 16'd50;
  localparam logic [CntW-1:0] MaxOut  = 8'd64;

  typedef enum logic [1:0] {
    CFG_QUEUE_CAPACITY = 2'd0,
    CFG_RESULT_LIMIT   = 2'd1,
    CFG_DROP_LIMIT     = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [RowW-1:0]          row;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t e;
  } cell_t;

  typedef struct packed {
    cell_t c;
    logic  tv;
    logic  ins;
  } link_t;

  typedef struct packed {
    cell_op_e        op;
    entry_t          item;
    logic            trunc;
    logic [CntW-1:0] cap_m1;
  } cell_ctrl_t;

endpackage

### design/tksd_if.sv
interface tksd_in_if;
  import tksd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [ScoreW-1:0] score;
  logic [RowW-1:0]          row_id;
  logic                     round_end;

  modport source (output valid, kind, score, row_id, round_end, input ready);
  modport sink   (input valid, kind, score, row_id, round_end, output ready);
endinterface

interface tksd_out_if;
  import tksd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ScoreW-1:0] out_score;
  logic [RowW-1:0]          out_row;
  logic [RankW-1:0]         rank_index;
  logic                     entry_valid;
  logic                     last_entry;
  logic                     seen_overflow;

  modport source (output valid, out_score, out_row, rank_index, entry_valid, last_entry,
                  seen_overflow, input ready);
  modport sink   (input valid, out_score, out_row, rank_index, entry_valid, last_entry,
                  seen_overflow, output ready);
endinterface

### design/tksd_ram.sv
module tksd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### design/tksd_cell.sv
module tksd_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tksd_pkg::cell_ctrl_t ctrl_i,
  input  tksd_pkg::link_t     left_i,
  input  tksd_pkg::cell_t     right_i,
  output tksd_pkg::link_t     link_o
);
  import tksd_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  cell_t q_q, q_d;
  logic  tv, go, ins;

  assign tv  = q_q.valid && (!ctrl_i.trunc || (IdxC < ctrl_i.cap_m1));
  assign go  = tv && (q_q.e.score > ctrl_i.item.score);
  assign ins = go || !tv;

  assign link_o = '{c: q_q, tv: tv, ins: ins};

  always_comb begin
    q_d = q_q;
    unique case (ctrl_i.op)
      CELL_HOLD:  q_d = q_q;
      CELL_CLEAR: q_d.valid = 1'b0;
      CELL_SHIFT: q_d = right_i;
      CELL_INSERT: begin
        if (ins && !left_i.ins) begin
          q_d = '{valid: 1'b1, e: ctrl_i.item};
        end else if (left_i.ins && left_i.tv) begin
          q_d = left_i.c;
        end else if (ins) begin
          q_d.valid = 1'b0;
        end
      end
      default: q_d = q_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end
endmodule

### design/top_k_smallest_with_dedup.sv
// Keeps the smallest-score candidates of a query in a sorted chain of MaxKept cells and drops
// row ids already seen, using an open-addressed hash table of SeenDepth ids in one RAM.
// A new candidate passes a hash read, a check and a cell insert, with one more check for each
// extra probe past an occupied slot of another id; a duplicate id ends at the check, and with a
// full table an unknown id probes all SeenDepth slots. A finish emits one result per cycle
// from the head of the chain while the receiver is ready, then a clearing pass writes every
// seen slot, during which no input is taken; the same pass runs after reset.
// Configuration writes are taken in any cycle.
module top_k_smallest_with_dedup (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tksd_pkg::CfgW-1:0]  cfg_data_i,
  tksd_in_if.sink                    in_i,
  tksd_out_if.source                 out_o
);
  import tksd_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(SeenDepth);
  localparam int unsigned IW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned SW = RowW + 1;
  localparam logic [CntW-1:0] MaxKeptC = CntW'(MaxKept);

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d, probe_q, probe_d, pcnt_q, pcnt_d;
  entry_t          item_q, item_d;
  logic            rend_q, rend_d;
  logic [CntW-1:0] count_q, count_d, rk_q, rk_d;
  logic [15:0]     drop_q, drop_d;
  logic            ovf_q, ovf_d;
  logic [6:0]      qcap_q, rlim_q;
  logic [15:0]     dlim_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr, hash_in;
  logic [SW-1:0]   ram_wdata, ram_rdata;

  cell_ctrl_t      ctrl;
  link_t           links [MaxKept];
  cell_t           last_cell;

  logic [6:0]      qc, c7;
  logic [CntW-1:0] cap, lim, n_out, eff;
  logic [15:0]     dl, dr;
  logic            hit, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcap_q <= DefCapacity;
      rlim_q <= DefLimit;
      dlim_q <= DefDrop;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_QUEUE_CAPACITY: qcap_q <= cfg_data_i[6:0];
        CFG_RESULT_LIMIT:   rlim_q <= cfg_data_i[6:0];
        CFG_DROP_LIMIT:     dlim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    qc  = (qcap_q == '0) ? DefCapacity : qcap_q;
    c7  = (qc > rlim_q) ? qc : rlim_q;
    cap = ({1'b0, c7} > MaxKeptC) ? MaxKeptC : {1'b0, c7};
    lim = ({1'b0, rlim_q} > cap) ? cap : {1'b0, rlim_q};
    lim = (lim > MaxOut) ? MaxOut : lim;
    n_out = (count_q < lim) ? count_q : lim;
    dl  = (dlim_q == '0) ? DefDrop : dlim_q;
    eff = (count_q >= cap) ? cap - 1'b1 : count_q;
  end

  always_comb begin
    hash_in = '0;
    for (int b = 0; b < RowW; b++) begin
      hash_in[b % AW] = hash_in[b % AW] ^ in_i.row_id[b];
    end
  end

  tksd_ram #(.Width(SW), .Depth(SeenDepth)) u_seen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  for (genvar i = 0; i < MaxKept; i++) begin : g_cell
    link_t l_in;
    cell_t r_in;
    if (i == 0) begin : g_first
      assign l_in = '0;
    end else begin : g_mid
      assign l_in = links[i-1];
    end
    if (i == MaxKept - 1) begin : g_last
      assign r_in = '0;
    end else begin : g_next
      assign r_in = links[i+1].c;
    end
    tksd_cell #(.Idx(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (l_in),
      .right_i (r_in),
      .link_o  (links[i])
    );
  end

  assign last_cell = links[IW'(count_q - 1'b1)].c;
  assign hit = ram_rdata[RowW] && (ram_rdata[RowW-1:0] == item_q.row);
  assign ram_raddr = (state_q == ST_IDLE) ? hash_in : probe_q + 1'b1;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    probe_d = probe_q;
    pcnt_d  = pcnt_q;
    item_d  = item_q;
    rend_d  = rend_q;
    count_d = count_q;
    rk_d    = rk_q;
    drop_d  = drop_q;
    ovf_d   = ovf_q;
    ram_we    = 1'b0;
    ram_waddr = probe_q;
    ram_wdata = {1'b1, item_q.row};
    ctrl = '{op: CELL_HOLD, item: item_q, trunc: count_q >= cap, cap_m1: cap - 1'b1};
    dr     = (drop_q == 16'hFFFF) ? drop_q : drop_q + 1'b1;
    accept = (count_q < cap) || (item_q.score < last_cell.e.score);
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    out_o.out_score     = '0;
    out_o.out_row       = '0;
    out_o.rank_index    = '0;
    out_o.entry_valid   = 1'b0;
    out_o.last_entry    = 1'b1;
    out_o.seen_overflow = ovf_q;

    unique case (state_q)
      ST_CLEAR: begin
        ctrl.op   = CELL_CLEAR;
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(SeenDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.kind) begin
            rk_d    = '0;
            state_d = ST_EMIT;
          end else begin
            item_d  = '{score: in_i.score, row: in_i.row_id};
            rend_d  = in_i.round_end;
            probe_d = hash_in;
            pcnt_d  = '0;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (hit) begin
          rk_d    = '0;
          state_d = (rend_q && drop_q >= dl) ? ST_EMIT : ST_IDLE;
        end else if (!ram_rdata[RowW]) begin
          ram_we  = 1'b1;
          state_d = ST_UPDATE;
        end else if (pcnt_q == '1) begin
          ovf_d   = 1'b1;
          state_d = ST_UPDATE;
        end else begin
          probe_d = probe_q + 1'b1;
          pcnt_d  = pcnt_q + 1'b1;
        end
      end
      ST_UPDATE: begin
        if (accept) begin
          ctrl.op = CELL_INSERT;
          count_d = eff + 1'b1;
          dr      = '0;
        end
        drop_d  = dr;
        rk_d    = '0;
        state_d = (rend_q && dr >= dl) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        out_o.valid = 1'b1;
        if (n_out != '0) begin
          out_o.out_score   = links[0].c.e.score;
          out_o.out_row     = links[0].c.e.row;
          out_o.rank_index  = RankW'(rk_q);
          out_o.entry_valid = 1'b1;
          out_o.last_entry  = (rk_q == n_out - 1'b1);
        end
        if (out_o.ready) begin
          ctrl.op = CELL_SHIFT;
          rk_d    = rk_q + 1'b1;
          if (out_o.last_entry) begin
            ctrl.op = CELL_CLEAR;
            count_d = '0;
            drop_d  = '0;
            ovf_d   = 1'b0;
            clr_d   = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      drop_q  <= '0;
      ovf_q   <= 1'b0;
      rk_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      ovf_q   <= ovf_d;
      rk_q    <= rk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    pcnt_q  <= pcnt_d;
    item_q  <= item_d;
    rend_q  <= rend_d;
  end

  `ASSERT_CLK(a_no_overlap, !(in_i.ready && out_o.valid), "input taken while emitting")
  `ASSERT_CLK(a_count_cap, (state_q == ST_UPDATE) && accept |=> count_q <= cap,
              "kept count exceeds capacity")
  `ASSERT_CLK(a_last_clears, out_o.valid && out_o.ready && out_o.last_entry |=>
              (state_q == ST_CLEAR) && (count_q == '0), "finish did not clear")
endmodule

### tb/tb_top_k_smallest_with_dedup.sv
`timescale 1ns / 100ps

module tb_top_k_smallest_with_dedup;
  import tksd_pkg::*;

  localparam int unsigned KEPT_MAX   = MaxKept;
  localparam int unsigned SEEN_SLOTS = SeenDepth;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          DRAIN_CYCLES = 1200;
  localparam int          LONG_HOLD_CYCLES = 3000;
  localparam bit          KIND_CAND = 1'b0;
  localparam bit          KIND_EXHAUST = 1'b1;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [RowW-1:0]          row;
    logic [RankW-1:0]         rank;
    logic                     valid;
    logic                     last;
    logic                     ovf;
  } topk_result_t;

  class topk_scoreboard;
    logic signed [ScoreW-1:0] kept_score[KEPT_MAX];
    logic [RowW-1:0]          kept_row[KEPT_MAX];
    int unsigned              kept_cnt;
    bit                       seen_rows[logic [RowW-1:0]];
    int unsigned              seen_cnt;
    int unsigned              drop_run;
    bit                       ovf_flag;
    int unsigned              queue_cap;
    int unsigned              res_limit;
    int unsigned              drop_lim;
    topk_result_t             pending_q[$];
    int                       errors;

    function new();
      queue_cap = 32'(DefCapacity);
      res_limit = 32'(DefLimit);
      drop_lim  = 32'(DefDrop);
      clear_query();
    endfunction

    function void clear_query();
      kept_cnt = 0;
      seen_rows.delete();
      seen_cnt = 0;
      drop_run = 0;
      ovf_flag = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_QUEUE_CAPACITY: queue_cap = 32'(val[6:0]);
        CFG_RESULT_LIMIT:   res_limit = 32'(val[6:0]);
        CFG_DROP_LIMIT:     drop_lim  = 32'(val);
        default: ;
      endcase
    endfunction

    function int unsigned capacity();
      int unsigned qc, c;
      qc = (queue_cap != 0) ? queue_cap : 32'(DefCapacity);
      c = (qc > res_limit) ? qc : res_limit;
      if (c > KEPT_MAX) c = KEPT_MAX;
      if (c < 1) c = 1;
      return c;
    endfunction

    function void keep_candidate(logic signed [ScoreW-1:0] s, logic [RowW-1:0] r);
      int unsigned cap, pos;
      if (seen_rows.exists(r)) return;
      if (seen_cnt < SEEN_SLOTS) begin
        seen_rows[r] = 1'b1;
        seen_cnt++;
      end else begin
        ovf_flag = 1'b1;
      end
      if (drop_run < 16'hFFFF) drop_run++;
      cap = capacity();
      if (kept_cnt < cap || s < kept_score[kept_cnt-1]) begin
        while (kept_cnt >= cap) kept_cnt--;
        pos = 0;
        while (pos < kept_cnt && kept_score[pos] <= s) pos++;
        for (int i = kept_cnt; i > pos; i--) begin
          kept_score[i] = kept_score[i-1];
          kept_row[i]   = kept_row[i-1];
        end
        kept_score[pos] = s;
        kept_row[pos]   = r;
        kept_cnt++;
        drop_run = 0;
      end
    endfunction

    function void emit_ranked();
      int unsigned lim, n;
      topk_result_t res;
      lim = res_limit;
      if (lim > capacity()) lim = capacity();
      if (lim > 32'(MaxOut)) lim = 32'(MaxOut);
      n = (kept_cnt < lim) ? kept_cnt : lim;
      if (n == 0) begin
        res = '0;
        res.last = 1'b1;
        res.ovf = ovf_flag;
        pending_q.insert(pending_q.size(), res);
      end
      for (int unsigned i = 0; i < n; i++) begin
        res.score = kept_score[i];
        res.row   = kept_row[i];
        res.rank  = i[RankW-1:0];
        res.valid = 1'b1;
        res.last  = (i + 1 == n);
        res.ovf   = ovf_flag;
        pending_q.insert(pending_q.size(), res);
      end
      clear_query();
    endfunction

    function void note_input(bit kind, logic signed [ScoreW-1:0] s, logic [RowW-1:0] r,
                             bit re);
      int unsigned dl;
      dl = (drop_lim != 0) ? drop_lim : 32'(DefDrop);
      if (kind == KIND_EXHAUST) begin
        emit_ranked();
        return;
      end
      keep_candidate(s, r);
      if (re && drop_run >= dl) emit_ranked();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(topk_result_t got);
      topk_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result score=%0d row=%h", got.score, got.row));
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.score !== exp_r.score)
        report($sformatf("out_score got %0d exp %0d", got.score, exp_r.score));
      if (got.row !== exp_r.row)
        report($sformatf("out_row got %h exp %h", got.row, exp_r.row));
      if (got.rank !== exp_r.rank)
        report($sformatf("rank_index got %0d exp %0d", got.rank, exp_r.rank));
      if (got.valid !== exp_r.valid)
        report($sformatf("entry_valid got %b exp %b", got.valid, exp_r.valid));
      if (got.last !== exp_r.last)
        report($sformatf("last_entry got %b exp %b", got.last, exp_r.last));
      if (got.ovf !== exp_r.ovf)
        report($sformatf("seen_overflow got %b exp %b", got.ovf, exp_r.ovf));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  tksd_in_if  in_if();
  tksd_out_if out_if();

  top_k_smallest_with_dedup u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  topk_scoreboard sb = new();
  int  cycle_cnt;
  bit  no_idle;
  bit  long_hold;
  logic [RowW-1:0] row_pool[24];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result({out_if.out_score, out_if.out_row, out_if.rank_index,
                       out_if.entry_valid, out_if.last_entry, out_if.seen_overflow});
  end

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        gap = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic write_cfg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_cfg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_item(bit kind, logic signed [ScoreW-1:0] s, logic [RowW-1:0] r, bit re);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.score     <= s;
    in_if.row_id    <= r;
    in_if.round_end <= re;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(kind, s, r, re);
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    in_if.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CfgW-1:0] cap, logic [CfgW-1:0] lim,
                           logic [CfgW-1:0] drop, int n_items);
    int sent, rsize;
    logic signed [ScoreW-1:0] s;
    logic [RowW-1:0] r;
    bit re;
    write_cfg(CFG_QUEUE_CAPACITY, cap);
    write_cfg(CFG_RESULT_LIMIT, lim);
    write_cfg(CFG_DROP_LIMIT, drop);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 24; i++) row_pool[i] = RowW'({$urandom, $urandom});
    sent = 0;
    while (sent < n_items) begin
      rsize = $urandom_range(1, 6);
      for (int k = 0; k < rsize; k++) begin
        case ($urandom_range(0, 3))
          0: s = $urandom;
          1: s = (int'($urandom_range(0, 8)) - 4) <<< 16;
          2: s = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default: s = int'($urandom_range(0, 4000)) - 2000;
        endcase
        r = $urandom_range(0, 1) ? row_pool[$urandom_range(0, 23)]
                                 : RowW'({$urandom, $urandom});
        re = (k == rsize - 1);
        if ($urandom_range(0, 9) == 0) re = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 39) == 0) send_item(KIND_EXHAUST, s, r, re);
        else send_item(KIND_CAND, s, r, re);
        sent++;
      end
    end
    send_item(KIND_EXHAUST, $urandom, RowW'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_QUEUE_CAPACITY;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.kind  <= KIND_CAND;
    in_if.score <= '0;
    in_if.row_id <= '0;
    in_if.round_end <= 1'b0;
    cycle_cnt = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(CFG_QUEUE_CAPACITY, 16'd64);
    write_cfg(CFG_RESULT_LIMIT, 16'd10);
    write_cfg(CFG_DROP_LIMIT, 16'd50);
    send_item(KIND_EXHAUST, '0, '0, 1'b0);
    send_item(KIND_CAND, 32'sh8000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_item(KIND_CAND, 32'sh7FFF_FFFF, 48'h0, 1'b0);
    send_item(KIND_CAND, 32'sh0, 48'h5, 1'b0);
    send_item(KIND_CAND, -32'sd9, 48'h5, 1'b0);
    send_item(KIND_CAND, 32'sh0, 48'h6, 1'b0);
    send_item(KIND_CAND, 32'sh1_0000, 48'h7, 1'b1);
    send_item(KIND_EXHAUST, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    wait_drained();

    write_cfg(CFG_QUEUE_CAPACITY, 16'd1);
    write_cfg(CFG_RESULT_LIMIT, 16'd1);
    write_cfg(CFG_DROP_LIMIT, 16'd1);
    send_item(KIND_CAND, 32'sd5, 48'h1, 1'b0);
    send_item(KIND_CAND, 32'sd10, 48'h2, 1'b1);
    send_item(KIND_CAND, 32'sd3, 48'h1, 1'b0);
    send_item(KIND_CAND, 32'sd3, 48'h4, 1'b1);
    send_item(KIND_CAND, 32'sd2, 48'hAAAA_5555_AAAA, 1'b1);
    send_item(KIND_EXHAUST, 32'sd0, 48'h0, 1'b0);
    wait_drained();

    long_hold = 1'b1;
    run_phase(16'd1, 16'd1, 16'd1, 30);
    run_phase(16'd0, 16'd64, 16'd0, 34);
    run_phase(16'd3, 16'd5, 16'd4, 34);
    run_phase(16'd127, 16'd127, 16'd65535, 34);
    run_phase(16'd64, 16'd0, 16'd2, 30);
    run_phase(16'd2, 16'd7, 16'd3, 34);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/tksd_pkg.sv
design/tksd_if.sv
design/tksd_ram.sv
design/tksd_cell.sv
design/top_k_smallest_with_dedup.sv
tb/tb_top_k_smallest_with_dedup.sv
